FILE: hdl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_WIDTH      = 40;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [1:0] {
        ST_NONE  = 2'd0,
        ST_ONE   = 2'd1,
        ST_TWO   = 2'd2,
        ST_AZERO = 2'd3
    } status_t;

endpackage

FILE: hdl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Forms the discriminant in two registered steps and classifies each word.
// ----------------------------------------------------------------------------
module qrs_front #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COEF_WIDTH-1:0]  coef_a,
    input  logic signed [COEF_WIDTH-1:0]  coef_b,
    input  logic signed [COEF_WIDTH-1:0]  coef_c,
    output logic                          out_valid,
    input  logic                          out_ready,
    output qrs_pkg::status_t              out_status,
    output logic signed [COEF_WIDTH-1:0]  out_a,
    output logic signed [COEF_WIDTH-1:0]  out_b,
    output logic [2*COEF_WIDTH+1:0]       out_d
);

    localparam int W  = COEF_WIDTH;
    localparam int DW = 2 * W + 2;

    logic                   en;
    logic                   v1_reg;
    logic signed [W-1:0]    a1_reg;
    logic signed [W-1:0]    b1_reg;
    logic signed [2*W-1:0]  bb1_reg;
    logic signed [2*W-1:0]  ac1_reg;
    logic signed [DW-1:0]   disc;
    qrs_pkg::status_t       st_next;
    logic                   v2_reg;
    qrs_pkg::status_t       st2_reg;
    logic signed [W-1:0]    a2_reg;
    logic signed [W-1:0]    b2_reg;
    logic [DW-1:0]          d2_reg;

    assign en       = !v2_reg || out_ready;
    assign in_ready = en;

    assign disc = DW'(bb1_reg) - (DW'(ac1_reg) <<< 2);

    always_comb
    begin
        priority if (a1_reg == '0)
            st_next = qrs_pkg::ST_AZERO;
        else if (disc[DW-1])
            st_next = qrs_pkg::ST_NONE;
        else if (disc == '0)
            st_next = qrs_pkg::ST_ONE;
        else
            st_next = qrs_pkg::ST_TWO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= coef_a;
            b1_reg  <= coef_b;
            bb1_reg <= (2*W)'(coef_b) * (2*W)'(coef_b);
            ac1_reg <= (2*W)'(coef_a) * (2*W)'(coef_c);
            st2_reg <= st_next;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
            d2_reg  <= (st_next == qrs_pkg::ST_TWO) ? disc : '0;
        end
    end

    assign out_valid  = v2_reg;
    assign out_status = st2_reg;
    assign out_a      = a2_reg;
    assign out_b      = b2_reg;
    assign out_d      = d2_reg;

endmodule

FILE: hdl/qrs_queue.sv
// ----------------------------------------------------------------------------
// qrs_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module qrs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qrs_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

endmodule

FILE: hdl/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back
// Pipelined square root, two pipelined dividers and output saturation to range.
// ----------------------------------------------------------------------------
module qrs_back #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  qrs_pkg::status_t                    in_status,
    input  logic signed [COEF_WIDTH-1:0]        in_a,
    input  logic signed [COEF_WIDTH-1:0]        in_b,
    input  logic [2*COEF_WIDTH+1:0]             in_d,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          root_status,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0] root_plus,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0] root_minus
);

    localparam int W   = COEF_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int SW  = W + F + 1;
    localparam int RW  = 2 * SW;
    localparam int RMW = SW + 2;
    localparam int QW  = W + F + 2;
    localparam int NW  = QW + 1;
    localparam int DVW = W + 1;
    localparam int OW  = qrs_pkg::OUT_WIDTH;
    localparam int XW  = ((QW > OW) ? QW : OW) + 1;

    logic en;

    logic               sq_v_reg    [0:SW];
    qrs_pkg::status_t   sq_st_reg   [0:SW];
    logic signed [W-1:0] sq_a_reg   [0:SW];
    logic signed [W-1:0] sq_b_reg   [0:SW];
    logic [RMW-1:0]     sq_rem_reg  [0:SW];
    logic [SW-1:0]      sq_root_reg [0:SW];
    logic [RW-1:0]      sq_rad_reg  [0:SW];

    logic                dv_v_reg    [0:QW];
    qrs_pkg::status_t    dv_st_reg   [0:QW];
    logic [DVW-1:0]      dv_dvsr_reg [0:QW];
    logic [DVW-1:0]      dv_prem_reg [0:QW];
    logic [QW-1:0]       dv_pq_reg   [0:QW];
    logic                dv_pneg_reg [0:QW];
    logic [DVW-1:0]      dv_mrem_reg [0:QW];
    logic [QW-1:0]       dv_mq_reg   [0:QW];
    logic                dv_mneg_reg [0:QW];

    logic signed [NW-1:0]  nb;
    logic signed [NW-1:0]  s_ext;
    logic signed [NW-1:0]  num_p;
    logic signed [NW-1:0]  num_m;
    logic signed [DVW-1:0] den;

    logic                  o_v_reg;
    logic [1:0]            o_st_reg;
    logic signed [OW-1:0]  o_p_reg;
    logic signed [OW-1:0]  o_m_reg;

    function automatic logic [OW-1:0] pack_root(input logic [QW-1:0] mag, input logic neg);
        logic [XW-1:0] m;
        logic [XW-1:0] lim;
        logic [XW-1:0] res;
        m = XW'(mag);
        if (neg)
        begin
            lim = XW'(1) << (OW - 1);
            if (m > lim)
                m = lim;
            res = -m;
        end
        else
        begin
            lim = (XW'(1) << (OW - 1)) - XW'(1);
            if (m > lim)
                m = lim;
            res = m;
        end
        return res[OW-1:0];
    endfunction

    assign en       = !o_v_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (en)
            sq_v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_st_reg[0]   <= in_status;
            sq_a_reg[0]    <= in_a;
            sq_b_reg[0]    <= in_b;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_rad_reg[0]  <= {in_d, {(2*F){1'b0}}};
        end
    end

    for (genvar i = 0; i < SW; i++)
    begin : g_sqrt
        logic [RMW+1:0] cat;
        logic [RMW+1:0] trial;
        logic           ge;

        assign cat   = {sq_rem_reg[i], sq_rad_reg[i][RW-1 -: 2]};
        assign trial = {2'b00, sq_root_reg[i], 2'b01};
        assign ge    = (cat >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[i+1] <= 1'b0;
            else if (en)
                sq_v_reg[i+1] <= sq_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_st_reg[i+1]   <= sq_st_reg[i];
                sq_a_reg[i+1]    <= sq_a_reg[i];
                sq_b_reg[i+1]    <= sq_b_reg[i];
                sq_rem_reg[i+1]  <= ge ? RMW'(cat - trial) : cat[RMW-1:0];
                sq_root_reg[i+1] <= {sq_root_reg[i][SW-2:0], ge};
                sq_rad_reg[i+1]  <= sq_rad_reg[i] << 2;
            end
        end
    end

    assign nb    = -(NW'(sq_b_reg[SW]) <<< F);
    assign s_ext = NW'($signed({1'b0, sq_root_reg[SW]}));
    assign num_p = nb + s_ext;
    assign num_m = nb - s_ext;
    assign den   = DVW'(sq_a_reg[SW]) <<< 1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (en)
            dv_v_reg[0] <= sq_v_reg[SW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_st_reg[0]   <= sq_st_reg[SW];
            dv_dvsr_reg[0] <= den[DVW-1] ? DVW'(-den) : DVW'(den);
            dv_prem_reg[0] <= '0;
            dv_pq_reg[0]   <= num_p[NW-1] ? QW'(-num_p) : QW'(num_p);
            dv_pneg_reg[0] <= num_p[NW-1] ^ den[DVW-1];
            dv_mrem_reg[0] <= '0;
            dv_mq_reg[0]   <= num_m[NW-1] ? QW'(-num_m) : QW'(num_m);
            dv_mneg_reg[0] <= num_m[NW-1] ^ den[DVW-1];
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        logic [DVW:0] pcat;
        logic [DVW:0] mcat;
        logic         pge;
        logic         mge;

        assign pcat = {dv_prem_reg[i], dv_pq_reg[i][QW-1]};
        assign mcat = {dv_mrem_reg[i], dv_mq_reg[i][QW-1]};
        assign pge  = (pcat >= {1'b0, dv_dvsr_reg[i]});
        assign mge  = (mcat >= {1'b0, dv_dvsr_reg[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[i+1] <= 1'b0;
            else if (en)
                dv_v_reg[i+1] <= dv_v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_st_reg[i+1]   <= dv_st_reg[i];
                dv_dvsr_reg[i+1] <= dv_dvsr_reg[i];
                dv_prem_reg[i+1] <= pge ? DVW'(pcat - {1'b0, dv_dvsr_reg[i]}) : pcat[DVW-1:0];
                dv_pq_reg[i+1]   <= {dv_pq_reg[i][QW-2:0], pge};
                dv_pneg_reg[i+1] <= dv_pneg_reg[i];
                dv_mrem_reg[i+1] <= mge ? DVW'(mcat - {1'b0, dv_dvsr_reg[i]}) : mcat[DVW-1:0];
                dv_mq_reg[i+1]   <= {dv_mq_reg[i][QW-2:0], mge};
                dv_mneg_reg[i+1] <= dv_mneg_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (en)
            o_v_reg <= dv_v_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_st_reg <= dv_st_reg[QW];
            o_p_reg  <= (dv_st_reg[QW] == qrs_pkg::ST_ONE || dv_st_reg[QW] == qrs_pkg::ST_TWO)
                        ? pack_root(dv_pq_reg[QW], dv_pneg_reg[QW]) : '0;
            o_m_reg  <= (dv_st_reg[QW] == qrs_pkg::ST_TWO)
                        ? pack_root(dv_mq_reg[QW], dv_mneg_reg[QW]) : '0;
        end
    end

    assign out_valid   = o_v_reg;
    assign root_status = o_st_reg;
    assign root_plus   = o_p_reg;
    assign root_minus  = o_m_reg;

endmodule

FILE: hdl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c as signed fixed point, one word per cycle when not stalled.
// ----------------------------------------------------------------------------
//  Channel  | Handshake           | Payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid, in_ready  | coef_a, coef_b, coef_c
//  output   | out_valid, out_ready| root_status, root_plus, root_minus
//
//  One word is accepted every cycle unless a stall holds the flow; each result
//  passes the square root stages (one root bit each) and the divider stages
//  (one quotient bit each). Reset clears all valid flags and the queue.
//  The front stalls only when the queue is full; the back stalls only when
//  its output word is not taken.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [COEF_WIDTH-1:0]         coef_a,
    input  logic signed [COEF_WIDTH-1:0]         coef_b,
    input  logic signed [COEF_WIDTH-1:0]         coef_c,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           root_status,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0] root_plus,
    output logic signed [qrs_pkg::OUT_WIDTH-1:0] root_minus
);

    localparam int W  = COEF_WIDTH;
    localparam int DW = 2 * W + 2;
    localparam int QWD = 2 + 2 * W + DW;

    logic                f_valid;
    logic                f_ready;
    qrs_pkg::status_t    f_status;
    logic signed [W-1:0] f_a;
    logic signed [W-1:0] f_b;
    logic [DW-1:0]       f_d;
    logic                q_valid;
    logic                q_ready;
    logic [QWD-1:0]      q_data;

    qrs_front #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coef_a     (coef_a),
        .coef_b     (coef_b),
        .coef_c     (coef_c),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_status (f_status),
        .out_a      (f_a),
        .out_b      (f_b),
        .out_d      (f_d)
    );

    qrs_queue #(
        .WIDTH (QWD),
        .DEPTH (qrs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_status, f_a, f_b, f_d}),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    qrs_back #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (q_valid),
        .in_ready    (q_ready),
        .in_status   (qrs_pkg::status_t'(q_data[QWD-1 -: 2])),
        .in_a        ($signed(q_data[QWD-3 -: W])),
        .in_b        ($signed(q_data[DW+W-1 -: W])),
        .in_d        (q_data[DW-1:0]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .root_status (root_status),
        .root_plus   (root_plus),
        .root_minus  (root_minus)
    );

    a_azero_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_status == qrs_pkg::ST_AZERO) |-> (root_plus == '0 && root_minus == '0))
        else $error("roots not zero for zero coefficient a");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_status == qrs_pkg::ST_NONE) |-> (root_plus == '0 && root_minus == '0))
        else $error("roots not zero when no real root");

    a_one_minus: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && root_status == qrs_pkg::ST_ONE) |-> (root_minus == '0))
        else $error("minus root not zero for a single root");

endmodule
